// ===== rtl/ttup_pkg.sv =====
package ttup_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int BASE_W          = 6;
	localparam int CHAR_W          = 8;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
	localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;

	localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
	localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

	typedef enum logic [2:0] {
		PH_DONE   = 3'd0,
		PH_LEAD   = 3'd1,
		PH_SIGNED = 3'd2,
		PH_ZERO   = 3'd3,
		PH_DIGITS = 3'd4
	} phase_t;

	// {is_digit, value 0..35}
	function automatic logic [BASE_W:0] digit_of(input logic [CHAR_W-1:0] c);
		logic [BASE_W:0] r;
		r = '0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, BASE_W'(c - 8'h30)};
		end else if (c inside {[8'h61:8'h7A]}) begin
			r = {1'b1, BASE_W'(c - 8'h61 + 8'd10)};
		end else if (c inside {[8'h41:8'h5A]}) begin
			r = {1'b1, BASE_W'(c - 8'h41 + 8'd10)};
		end
		return r;
	endfunction

endpackage

// ===== rtl/ttup_digit.sv =====
module ttup_digit #(
	parameter int VALUE_WIDTH = ttup_pkg::VALUE_WIDTH_DEF
) (
	input  logic [VALUE_WIDTH-1:0]       acc,
	input  logic [ttup_pkg::BASE_W-1:0]  base,
	input  logic [ttup_pkg::CHAR_W-1:0]  ch,
	output logic                         stop,
	output logic                         ovf,
	output logic [VALUE_WIDTH-1:0]       acc_next
);
	import ttup_pkg::*;

	localparam int PW = VALUE_WIDTH + BASE_W;
	localparam int SW = PW + 1;

	logic [BASE_W:0]   dig;
	logic [BASE_W-1:0] dval;
	logic [PW-1:0]     prod;
	logic [SW-1:0]     sum;

	assign dig  = digit_of(ch);
	assign dval = dig[BASE_W-1:0];
	assign stop = !dig[BASE_W] || (dval >= base);

	// acc*base + d beyond the value width means overflow
	assign prod     = PW'(acc) * PW'(base);
	assign sum      = SW'(prod) + SW'(dval);
	assign ovf      = |sum[SW-1:VALUE_WIDTH];
	assign acc_next = sum[VALUE_WIDTH-1:0];

endmodule

// ===== rtl/text_to_unsigned_parser.sv =====
// Items pass the input register stage, then results leave from the result register.
// Throughput: one character item per cycle, sustained while m_tready is high; one
// digit step (a multiply by a 6-bit base and an overflow check) per cycle.
// Reset: arst_n asynchronous, active low; clears the item valids and puts the
// parser in the done phase, so characters are ignored until a start item arrives.
module text_to_unsigned_parser #(
	parameter int VALUE_WIDTH = ttup_pkg::VALUE_WIDTH_DEF,
	parameter int COUNT_WIDTH = ttup_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items: one character each
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [5:0] base_req, [13:6] ch, [15:14] zero
	input  logic        s_tuser,  // [0] start_req
	// result items: one per finished conversion
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [((VALUE_WIDTH+COUNT_WIDTH+7)/8)*8-1:0] m_tdata,
	                    // [VALUE_WIDTH-1:0] value, then consumed_count, then zero fill
	output logic        m_tuser   // [0] overflowed
);
	import ttup_pkg::*;

	localparam int OUT_W = ((VALUE_WIDTH + COUNT_WIDTH + 7) / 8) * 8;

	// ---------------- input register stage ----------------
	logic              s1_valid_q;
	logic              start_s1;
	logic [BASE_W-1:0] base_s1;
	logic [CHAR_W-1:0] ch_s1;
	logic              adv;

	// the stage moves on whenever the result register is free or being drained
	assign adv      = s1_valid_q && (!m_tvalid || m_tready);
	assign s_tready = !s1_valid_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			start_s1 <= s_tuser;
			base_s1  <= s_tdata[BASE_W-1:0];
			ch_s1    <= s_tdata[BASE_W+CHAR_W-1:BASE_W];
		end
	end

	// ---------------- conversion state ----------------
	phase_t                  phase_q,  phase_n;
	logic [VALUE_WIDTH-1:0]  acc_q,    acc_n;
	logic [BASE_W-1:0]       base_q,   base_n;
	logic [COUNT_WIDTH-1:0]  cnt_q,    cnt_n;

	// a start item restarts the conversion before its character is looked at
	phase_t                  eff_phase;
	logic [VALUE_WIDTH-1:0]  eff_acc;
	logic [BASE_W-1:0]       eff_base;
	logic [COUNT_WIDTH-1:0]  eff_cnt;
	logic [COUNT_WIDTH-1:0]  cnt_inc;

	assign eff_phase = start_s1 ? PH_LEAD : phase_q;
	assign eff_acc   = start_s1 ? '0 : acc_q;
	assign eff_base  = start_s1 ? base_s1 : base_q;
	assign eff_cnt   = start_s1 ? '0 : cnt_q;
	assign cnt_inc   = (&eff_cnt) ? eff_cnt : eff_cnt + COUNT_WIDTH'(1);

	// one shared digit unit; auto base falls to decimal when no '0' leads
	logic [BASE_W-1:0]      dig_base;
	logic                   dig_stop;
	logic                   dig_ovf;
	logic [VALUE_WIDTH-1:0] dig_acc;

	assign dig_base = (eff_base == BASE_AUTO) ? BASE_DEC : eff_base;

	ttup_digit #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_digit (
		.acc      (eff_acc),
		.base     (dig_base),
		.ch       (ch_s1),
		.stop     (dig_stop),
		.ovf      (dig_ovf),
		.acc_next (dig_acc)
	);

	logic                   emit;
	logic [VALUE_WIDTH-1:0] res_value;
	logic                   res_ovf;
	logic                   go_signed;
	logic                   do_digit;
	logic                   is_ws;

	assign is_ws = (ch_s1 == CH_SPACE) || (ch_s1 == CH_TAB) ||
	               (ch_s1 == CH_LF) || (ch_s1 == CH_CR);

	always_comb begin
		phase_n   = eff_phase;
		acc_n     = eff_acc;
		base_n    = eff_base;
		cnt_n     = eff_cnt;
		emit      = 1'b0;
		res_value = eff_acc;
		res_ovf   = 1'b0;
		go_signed = 1'b0;
		do_digit  = 1'b0;

		case (eff_phase)
			PH_DONE: begin
			end
			PH_LEAD: begin
				if (is_ws) begin
					cnt_n = cnt_inc;
				end else if (ch_s1 == CH_PLUS) begin
					cnt_n   = cnt_inc;
					phase_n = PH_SIGNED;
				end else begin
					go_signed = 1'b1;
				end
			end
			PH_SIGNED: begin
				go_signed = 1'b1;
			end
			PH_ZERO: begin
				if (ch_s1 == CH_X_LO || ch_s1 == CH_X_UP) begin
					base_n  = BASE_HEX;
					cnt_n   = cnt_inc;
					phase_n = PH_DIGITS;
				end else begin
					do_digit = 1'b1;
				end
			end
			PH_DIGITS: begin
				do_digit = 1'b1;
			end
			default: begin
				phase_n = PH_DONE;
			end
		endcase

		// sign seen (or skipped): look for a leading zero / prefix
		if (go_signed) begin
			if (eff_base == BASE_AUTO) begin
				if (ch_s1 == CH_ZERO) begin
					base_n  = BASE_OCT;
					cnt_n   = cnt_inc;
					phase_n = PH_ZERO;
				end else begin
					base_n   = BASE_DEC;
					do_digit = 1'b1;
				end
			end else if (eff_base == BASE_HEX && ch_s1 == CH_ZERO) begin
				cnt_n   = cnt_inc;
				phase_n = PH_ZERO;
			end else begin
				do_digit = 1'b1;
			end
		end

		if (do_digit) begin
			phase_n = PH_DIGITS;
			if (dig_stop) begin
				emit    = 1'b1;
				phase_n = PH_DONE;
			end else if (dig_ovf) begin
				emit      = 1'b1;
				res_value = '1;
				res_ovf   = 1'b1;
				phase_n   = PH_DONE;
			end else begin
				acc_n = dig_acc;
				cnt_n = cnt_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DONE;
			acc_q   <= '0;
			base_q  <= '0;
			cnt_q   <= '0;
		end else if (adv) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			base_q  <= base_n;
			cnt_q   <= cnt_n;
		end
	end

	// ---------------- result register ----------------
	logic [VALUE_WIDTH-1:0] value_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   ovf_q;
	logic                   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			value_q <= res_value;
			count_q <= eff_cnt;
			ovf_q   <= res_ovf;
		end
	end

	// zero fill up to whole bytes
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({count_q, value_q});
	assign m_tuser  = ovf_q;

endmodule
